// ===== src/kas_pkg.sv =====
// kas_pkg: types, codes and constants shared by the key autorepeat synthesizer
// used by kas_ifs.sv and key_autorepeat_synthesizer.sv; no dependencies
package kas_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int Q_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CW = $clog2(QUEUE_DEPTH + 1);

    localparam int TIME_W   = 22;
    localparam int KIND_W   = 3;
    localparam int KEY_W    = 16;
    localparam int UTF_W    = 21;
    localparam int CFG_IX_W = 8;

    localparam logic [TIME_W-1:0] RST_DELAY_US   = TIME_W'(300000);
    localparam logic [TIME_W-1:0] RST_TIMEOUT_US = TIME_W'(100000);
    localparam logic [TIME_W-1:0] RST_PERIOD_US  = TIME_W'(20000);

    typedef logic [TIME_W-1:0] t_time;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE     = 3'd0,
        KIND_KPRESS   = 3'd1,
        KIND_KRELEASE = 3'd2,
        KIND_MPRESS   = 3'd3,
        KIND_MRELEASE = 3'd4,
        KIND_MOTION   = 3'd5,
        KIND_RESIZE   = 3'd6,
        KIND_QUIT     = 3'd7
    } t_kind;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_REPEAT_ENABLE   = 8'd0,
        CFG_REPEAT_DELAY    = 8'd1,
        CFG_RELEASE_TIMEOUT = 8'd2,
        CFG_REPEAT_PERIOD   = 8'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key_or_x;
        logic [UTF_W-1:0]  utf32_or_y;
    } t_evt;

    localparam int EVT_W = $bits(t_evt);

    function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] ptr);
        logic [Q_AW-1:0] nxt;
        if (ptr == Q_AW'(QUEUE_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + Q_AW'(1);
        end
        return nxt;
    endfunction

    function automatic t_time sat_add(input t_time a, input t_time b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? '1 : s[TIME_W-1:0];
    endfunction

endpackage

// ===== src/kas_ifs.sv =====
// kas_ifs: handshake channel interfaces for poll input, result output and config writes
// depends on kas_pkg
interface kas_in_if;
    logic                         valid;
    logic                         ready;
    logic [kas_pkg::TIME_W-1:0]   elapsed_us;
    logic [kas_pkg::KIND_W-1:0]   raw_kind;
    logic [kas_pkg::KEY_W-1:0]    raw_key_or_x;
    logic [kas_pkg::UTF_W-1:0]    raw_utf32_or_y;

    modport source (output valid, elapsed_us, raw_kind, raw_key_or_x, raw_utf32_or_y,
                    input ready);
    modport sink   (input valid, elapsed_us, raw_kind, raw_key_or_x, raw_utf32_or_y,
                    output ready);
endinterface

interface kas_out_if;
    logic                         valid;
    logic                         ready;
    logic [kas_pkg::KIND_W-1:0]   out_kind;
    logic [kas_pkg::KEY_W-1:0]    out_key_or_x;
    logic [kas_pkg::UTF_W-1:0]    out_utf32_or_y;
    logic                         raw_taken;

    modport source (output valid, out_kind, out_key_or_x, out_utf32_or_y, raw_taken,
                    input ready);
    modport sink   (input valid, out_kind, out_key_or_x, out_utf32_or_y, raw_taken,
                    output ready);
endinterface

interface kas_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [kas_pkg::CFG_IX_W-1:0]   index;
    logic [kas_pkg::TIME_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/key_autorepeat_synthesizer.sv =====
// key_autorepeat_synthesizer: keyboard typematic repeat and release synthesis
// with a pending event queue held in kas_ram; depends on kas_pkg, kas_ifs, kas_ram
//
//  channel  dir  beat contents
//  i_in     in   elapsed_us, raw_kind, raw_key_or_x, raw_utf32_or_y
//  o_out    out  out_kind, out_key_or_x, out_utf32_or_y, raw_taken
//  i_cfg    in   index, data (register write)
//
// a poll's beat is captured while the queue head is read from the ram; the result
// is then formed and loaded into the output register, and no new poll is taken
// until that load is done.
// a poll is taken while an earlier result still waits in the output register;
// the compute cycle repeats while that register is full and not drained.
// synchronous active-low reset clears control state; the queue ram needs no clearing.
module key_autorepeat_synthesizer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kas_in_if.sink    i_in,
    kas_out_if.source o_out,
    kas_cfg_if.sink   i_cfg
);

    logic                    r_enable;
    kas_pkg::t_time          r_delay;
    kas_pkg::t_time          r_timeout;
    kas_pkg::t_time          r_period;

    logic                    r_held_valid, n_held_valid;
    logic [kas_pkg::KEY_W-1:0] r_held_key, n_held_key;
    logic [kas_pkg::UTF_W-1:0] r_held_utf, n_held_utf;
    kas_pkg::t_time          r_since, n_since;
    kas_pkg::t_time          r_accum, n_accum;

    logic [kas_pkg::Q_AW-1:0] r_head, n_head;
    logic [kas_pkg::Q_AW-1:0] r_tail, n_tail;
    logic [kas_pkg::Q_CW-1:0] r_count, n_count;

    logic                    r_busy;
    kas_pkg::t_time          r_elapsed;
    kas_pkg::t_evt           r_raw;

    logic                    r_out_valid;
    kas_pkg::t_evt           r_out_evt, n_out_evt;
    logic                    r_out_taken;

    logic                    in_acc;
    logic                    fire;
    logic                    popped;
    logic                    push;
    logic [kas_pkg::Q_CW-1:0] cnt_after_pop;
    logic [kas_pkg::EVT_W-1:0] ram_rdata;
    kas_pkg::t_evt           ev;
    kas_pkg::t_time          sp, ra;
    logic                    is_kpress;

    kas_ram #(
        .WIDTH (kas_pkg::EVT_W),
        .DEPTH (kas_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_tail),
        .i_wdata (ev),
        .i_re    (in_acc),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready  = !r_busy;
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && !r_busy;
    assign fire        = r_busy && (!r_out_valid || o_out.ready);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b1;
            r_delay   <= kas_pkg::RST_DELAY_US;
            r_timeout <= kas_pkg::RST_TIMEOUT_US;
            r_period  <= kas_pkg::RST_PERIOD_US;
        end else if (i_cfg.valid) begin
            unique case (kas_pkg::t_cfg_idx'(i_cfg.index))
                kas_pkg::CFG_REPEAT_ENABLE:   r_enable  <= i_cfg.data[0];
                kas_pkg::CFG_REPEAT_DELAY:    r_delay   <= i_cfg.data;
                kas_pkg::CFG_RELEASE_TIMEOUT: r_timeout <= i_cfg.data;
                kas_pkg::CFG_REPEAT_PERIOD:   r_period  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // event selection and repeat logic
    always_comb begin
        popped        = (r_count != '0);
        ev            = popped ? kas_pkg::t_evt'(ram_rdata) : r_raw;
        cnt_after_pop = r_count - kas_pkg::Q_CW'(popped);
        is_kpress     = (ev.kind == kas_pkg::KIND_KPRESS);
        sp            = kas_pkg::sat_add(r_since, r_elapsed);
        ra            = kas_pkg::sat_add(r_accum, r_elapsed);

        n_out_evt    = ev;
        n_held_valid = r_held_valid;
        n_held_key   = r_held_key;
        n_held_utf   = r_held_utf;
        n_since      = r_since;
        n_accum      = r_accum;
        push         = 1'b0;

        if (r_enable) begin
            n_since = sp;
            n_accum = ra;
            if (r_held_valid && (ra > r_delay) && (ra > r_timeout) && (ra > r_period)) begin
                push      = 1'b1;
                n_accum   = ra - r_period;
                n_out_evt = '{kind: kas_pkg::KIND_KPRESS, key_or_x: r_held_key,
                              utf32_or_y: r_held_utf};
            end else if (is_kpress && r_held_valid && (ev.key_or_x == r_held_key)
                         && (ev.utf32_or_y == r_held_utf)) begin
                n_since   = '0;
                n_out_evt = '{kind: kas_pkg::KIND_NONE, key_or_x: '0, utf32_or_y: '0};
            end else if (r_held_valid && ((sp > r_timeout) || is_kpress)) begin
                push         = 1'b1;
                n_held_valid = 1'b0;
                n_out_evt    = '{kind: kas_pkg::KIND_KRELEASE, key_or_x: r_held_key,
                                 utf32_or_y: r_held_utf};
            end else if (is_kpress) begin
                n_since      = '0;
                n_accum      = '0;
                n_held_valid = 1'b1;
                n_held_key   = ev.key_or_x;
                n_held_utf   = ev.utf32_or_y;
            end
        end

        // none events are never queued, nor anything into a full queue
        push = fire && push && (ev.kind != kas_pkg::KIND_NONE)
               && (cnt_after_pop < kas_pkg::Q_CW'(kas_pkg::QUEUE_DEPTH));

        n_head  = popped ? kas_pkg::ptr_inc(r_head) : r_head;
        n_tail  = push ? kas_pkg::ptr_inc(r_tail) : r_tail;
        n_count = cnt_after_pop + kas_pkg::Q_CW'(push);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_key   <= '0;
            r_held_utf   <= '0;
            r_since      <= '0;
            r_accum      <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (fire) begin
                r_busy <= 1'b0;
            end
            if (fire) begin
                r_out_valid  <= 1'b1;
                r_held_valid <= n_held_valid;
                r_held_key   <= n_held_key;
                r_held_utf   <= n_held_utf;
                r_since      <= n_since;
                r_accum      <= n_accum;
                r_head       <= n_head;
                r_tail       <= n_tail;
                r_count      <= n_count;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_elapsed <= i_in.elapsed_us;
            r_raw     <= '{kind: i_in.raw_kind, key_or_x: i_in.raw_key_or_x,
                           utf32_or_y: i_in.raw_utf32_or_y};
        end
        if (fire) begin
            r_out_evt   <= n_out_evt;
            r_out_taken <= !popped;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_kind       = r_out_evt.kind;
    assign o_out.out_key_or_x   = r_out_evt.key_or_x;
    assign o_out.out_utf32_or_y = r_out_evt.utf32_or_y;
    assign o_out.raw_taken      = r_out_taken;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= kas_pkg::Q_CW'(kas_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_busy)
        else $error("accepted poll not in flight");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy))
        else $error("result without a poll in flight");

    a_queue_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty queue with unequal pointers");
`endif

endmodule

// ===== src/kas_ram.sv =====
// kas_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies
module kas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/key_autorepeat_synthesizer_tb.sv =====
// key_autorepeat_synthesizer_tb: self-checking bench for the key autorepeat synthesizer
// predicts every delivered event from a behavioral copy of the block state and compares beats
// depends on kas_pkg, kas_ifs and the key_autorepeat_synthesizer rtl
module key_autorepeat_synthesizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kas_pkg::*;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key_or_x;
        logic [UTF_W-1:0]  utf32_or_y;
        logic              raw_taken;
    } t_delivery;

    logic i_clk;
    logic i_rst_n;

    kas_in_if  in_bus ();
    kas_out_if out_bus ();
    kas_cfg_if cfg_bus ();

    key_autorepeat_synthesizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    // predictor state
    logic      cfg_enable  = 1'b1;
    t_time     cfg_delay   = RST_DELAY_US;
    t_time     cfg_timeout = RST_TIMEOUT_US;
    t_time     cfg_period  = RST_PERIOD_US;
    logic      held_valid  = 1'b0;
    t_evt      held_key    = '0;
    t_time     since_press = '0;
    t_time     repeat_accum = '0;
    t_evt      pending_events[$];
    t_delivery expected_deliveries[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("key_autorepeat_synthesizer_tb NOT OK");
        $finish;
    end

    function automatic t_time clamp_sum(input t_time a, input t_time b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[TIME_W]) begin
            return '1;
        end
        return s[TIME_W-1:0];
    endfunction

    function automatic void hold_back(input t_evt ev);
        if (ev.kind != KIND_NONE && pending_events.size() < QUEUE_DEPTH) begin
            pending_events.push_back(ev);
        end
    endfunction

    function automatic t_delivery predict_delivery(input t_time elapsed, input t_evt raw);
        t_evt      ev;
        t_evt      res;
        t_delivery d;
        if (pending_events.size() > 0) begin
            ev = pending_events.pop_front();
            d.raw_taken = 1'b0;
        end else begin
            ev = raw;
            d.raw_taken = 1'b1;
        end
        res = ev;
        if (cfg_enable) begin
            since_press  = clamp_sum(since_press, elapsed);
            repeat_accum = clamp_sum(repeat_accum, elapsed);
            if (held_valid && repeat_accum > cfg_delay && repeat_accum > cfg_timeout
                && repeat_accum > cfg_period) begin
                hold_back(ev);
                repeat_accum = repeat_accum - cfg_period;
                res = held_key;
                res.kind = KIND_KPRESS;
            end else if (ev.kind == KIND_KPRESS && held_valid
                         && ev.key_or_x == held_key.key_or_x
                         && ev.utf32_or_y == held_key.utf32_or_y) begin
                since_press = '0;
                res = '0;
            end else if (held_valid && (since_press > cfg_timeout || ev.kind == KIND_KPRESS)) begin
                hold_back(ev);
                res = held_key;
                res.kind = KIND_KRELEASE;
                held_valid = 1'b0;
            end else if (ev.kind == KIND_KPRESS) begin
                since_press  = '0;
                repeat_accum = '0;
                held_key     = ev;
                held_valid   = 1'b1;
            end
        end
        d.kind       = res.kind;
        d.key_or_x   = res.key_or_x;
        d.utf32_or_y = res.utf32_or_y;
        return d;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic check_delivery();
        t_delivery want;
        if (expected_deliveries.size() == 0) begin
            report_mismatch("unexpected beat kind", 32'(out_bus.out_kind), 32'hffffffff);
        end else begin
            want = expected_deliveries.pop_front();
            if (out_bus.out_kind !== want.kind) begin
                report_mismatch("kind", 32'(out_bus.out_kind), 32'(want.kind));
            end
            if (out_bus.out_key_or_x !== want.key_or_x) begin
                report_mismatch("key_or_x", 32'(out_bus.out_key_or_x), 32'(want.key_or_x));
            end
            if (out_bus.out_utf32_or_y !== want.utf32_or_y) begin
                report_mismatch("utf32_or_y", 32'(out_bus.out_utf32_or_y),
                                32'(want.utf32_or_y));
            end
            if (out_bus.raw_taken !== want.raw_taken) begin
                report_mismatch("raw_taken", 32'(out_bus.raw_taken), 32'(want.raw_taken));
            end
        end
    endtask

    // result side
    initial begin
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
                check_delivery();
            end
            out_bus.ready <= (i_rst_n === 1'b1) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_poll(input t_time elapsed, input t_kind kind,
                             input logic [KEY_W-1:0] key, input logic [UTF_W-1:0] utf);
        t_evt raw;
        if ($urandom_range(99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_bus.valid          <= 1'b1;
        in_bus.elapsed_us     <= elapsed;
        in_bus.raw_kind       <= kind;
        in_bus.raw_key_or_x   <= key;
        in_bus.raw_utf32_or_y <= utf;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        raw.kind       = kind;
        raw.key_or_x   = key;
        raw.utf32_or_y = utf;
        expected_deliveries.push_back(predict_delivery(elapsed, raw));
    endtask

    task automatic drain();
        in_bus.valid <= 1'b0;
        while (expected_deliveries.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_time value);
        drain();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        cfg_bus.valid <= 1'b0;
        case (idx)
            CFG_REPEAT_ENABLE:   cfg_enable  = value[0];
            CFG_REPEAT_DELAY:    cfg_delay   = value;
            CFG_RELEASE_TIMEOUT: cfg_timeout = value;
            CFG_REPEAT_PERIOD:   cfg_period  = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic en, input t_time dly, input t_time tmo,
                                  input t_time per);
        write_reg(CFG_REPEAT_ENABLE, t_time'(en));
        write_reg(CFG_REPEAT_DELAY, dly);
        write_reg(CFG_RELEASE_TIMEOUT, tmo);
        write_reg(CFG_REPEAT_PERIOD, per);
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
        endcase
    endtask

    task automatic test_default_timing();
        set_idling(0);
        send_poll('0, KIND_NONE, '0, '0);
        send_poll('0, KIND_QUIT, '1, UTF_W'(1114111));
        send_poll(22'd5, KIND_MPRESS, '1, '0);
        send_poll(22'd5, KIND_MRELEASE, '0, UTF_W'(1114111));
        send_poll(22'd5, KIND_MOTION, 16'h5a5a, UTF_W'(21'h0a5a5a));
        send_poll(22'd5, KIND_RESIZE, 16'ha5a5, UTF_W'(21'h05a5a5));
        send_poll('0, KIND_KRELEASE, 16'h0041, 21'h41);
        // press, same press swallowed, then one repeat past the delay
        send_poll('0, KIND_KPRESS, '1, UTF_W'(1114111));
        send_poll(22'd50000, KIND_KPRESS, '1, UTF_W'(1114111));
        send_poll(22'd310000, KIND_NONE, '0, '0);
        // another repeat while the accumulator is still past the delay
        send_poll('0, KIND_NONE, '0, '0);
        // new press displaces the held key and comes back from the queue
        send_poll('0, KIND_KPRESS, '0, '0);
        send_poll(22'd10, KIND_KPRESS, 16'h0062, 21'h62);
        send_poll('0, KIND_MOTION, 16'h0001, 21'h1);
        // the queued press returns and is held; the raw key release is not taken
        send_poll(22'd100001, KIND_KRELEASE, 16'h0062, 21'h62);
        send_poll('0, KIND_NONE, '0, '0);
        // saturated accumulators repeat on consecutive polls
        send_poll('0, KIND_KPRESS, 16'h0063, 21'h63);
        send_poll('1, KIND_MOTION, 16'h0002, 21'h2);
        send_poll('1, KIND_QUIT, '0, '0);
        send_poll('1, KIND_NONE, '0, '0);
    endtask

    task automatic test_disabled_passthrough();
        set_idling(1);
        apply_settings(1'b0, RST_DELAY_US, RST_TIMEOUT_US, RST_PERIOD_US);
        send_poll('1, KIND_KPRESS, 16'h0071, 21'h71);
        send_poll('1, KIND_KPRESS, 16'h0071, 21'h71);
        send_poll('1, KIND_MOTION, 16'h0003, 21'h3);
        write_reg(CFG_REPEAT_ENABLE, t_time'(1));
        send_poll(22'd1, KIND_NONE, '0, '0);
        send_poll(22'd1, KIND_NONE, '0, '0);
    endtask

    task automatic test_extreme_settings();
        set_idling(3);
        apply_settings(1'b1, '0, '0, t_time'(1));
        send_poll('0, KIND_KPRESS, 16'h0080, 21'h80);
        send_poll(22'd2, KIND_NONE, '0, '0);
        send_poll(22'd1, KIND_MPRESS, 16'h0004, 21'h4);
        send_poll(22'd1, KIND_NONE, '0, '0);
        apply_settings(1'b1, '1, '1, '1);
        send_poll('0, KIND_KPRESS, 16'h0090, 21'h90);
        send_poll('1, KIND_NONE, '0, '0);
        send_poll('1, KIND_KPRESS, 16'h0091, 21'h91);
        send_poll('1, KIND_NONE, '0, '0);
    endtask

    function automatic t_time pick_elapsed(input int unsigned span);
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return t_time'($urandom());
            default: return t_time'($urandom_range(0, span));
        endcase
    endfunction

    task automatic run_random_phase(input logic en, input t_time dly, input t_time tmo,
                                    input t_time per, input int mode);
        logic [KEY_W-1:0] pool_key [2];
        logic [UTF_W-1:0] pool_utf [2];
        logic [KEY_W-1:0] key;
        logic [UTF_W-1:0] utf;
        t_kind            kind;
        int unsigned      span;
        int unsigned      pick;
        int unsigned      slot;
        apply_settings(en, dly, tmo, per);
        set_idling(mode);
        span = 32'(dly);
        if (tmo > span) begin
            span = 32'(tmo);
        end
        if (per > span) begin
            span = 32'(per);
        end
        span = span / 3 + 1;
        for (int i = 0; i < 2; i++) begin
            pool_key[i] = KEY_W'($urandom_range(0, 65535));
            pool_utf[i] = UTF_W'($urandom_range(0, 1114111));
        end
        repeat (200) begin
            pick = $urandom_range(99);
            slot = $urandom_range(1);
            key  = KEY_W'($urandom_range(0, 65535));
            utf  = UTF_W'($urandom_range(0, 1114111));
            if (pick < 40) begin
                kind = KIND_KPRESS;
                key  = pool_key[slot];
                utf  = pool_utf[slot];
            end else if (pick < 48) begin
                kind = KIND_KPRESS;
            end else begin
                kind = t_kind'($urandom_range(7));
            end
            send_poll(pick_elapsed(span), kind, key, utf);
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(1'b1, RST_DELAY_US, RST_TIMEOUT_US, RST_PERIOD_US, 0);
        run_random_phase(1'b1, '0, '0, t_time'(1), 1);
        run_random_phase(1'b1, '1, '1, '1, 2);
        run_random_phase(1'b0, RST_DELAY_US, RST_TIMEOUT_US, RST_PERIOD_US, 3);
        run_random_phase(1'b1, t_time'(5000), t_time'(50000), t_time'(1000), 1);
        run_random_phase(1'b1, t_time'($urandom_range(0, 400000)),
                         t_time'($urandom_range(0, 400000)),
                         t_time'($urandom_range(1, 60000)), 2);
        run_random_phase(1'b1, t_time'($urandom()), t_time'($urandom()),
                         t_time'($urandom_range(1, 4194303)), 3);
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        in_bus.valid          <= 1'b0;
        in_bus.elapsed_us     <= '0;
        in_bus.raw_kind       <= KIND_NONE;
        in_bus.raw_key_or_x   <= '0;
        in_bus.raw_utf32_or_y <= '0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= CFG_REPEAT_ENABLE;
        cfg_bus.data          <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_timing();
        test_disabled_passthrough();
        test_extreme_settings();
        test_random_traffic();

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("key_autorepeat_synthesizer_tb OK");
        end else begin
            $display("key_autorepeat_synthesizer_tb NOT OK");
        end
        $finish;
    end

endmodule
